// ===== src/tdpc_pkg.sv =====
// ----------------------------------------------------------------------------
// tdpc_pkg
// shared constants and types of the trial-division prime counter
// ----------------------------------------------------------------------------
package tdpc_pkg;

  localparam int CAND_W          = 16;  // candidate field width
  localparam int CNT_W           = 16;  // running count width
  localparam int OUT_TDATA_W     = 40;  // echo, flag and count rounded to bytes
  localparam int NUMBER_BITS_DEF = 16;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_DONE  = 4'b1000
  } tdpc_state_t;

  // verdict handed from the sequencer to the top level
  typedef struct packed {
    logic valid;
    logic prime;
  } tdpc_res_t;

endpackage

// ===== src/tdpc_rem_unit.sv =====
// ----------------------------------------------------------------------------
// tdpc_rem_unit
// bit-serial restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
module tdpc_rem_unit #(
  parameter int NUM_W = 16,
  parameter int DIV_W = 9
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,   // held stable while busy
  output logic             done,      // one-cycle pulse
  output logic             rem_zero   // valid with done
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] rem_nxt;
  logic [NUM_W-1:0] quo_r;
  logic [DIV_W:0]   trial;

  // shift in the next dividend bit, subtract when it fits
  always_comb begin
    trial = {rem_r, quo_r[NUM_W-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_nxt = DIV_W'(trial - {1'b0, divisor});
    end else begin
      rem_nxt = trial[DIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= CW'(NUM_W);
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      rem_r <= rem_nxt;
      quo_r <= {quo_r[NUM_W-2:0], 1'b0};
    end
  end

  assign done     = done_r;
  assign rem_zero = (rem_r == '0);

endmodule

// ===== src/tdpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// tdpc_ctrl
// divisor sequencer: steps d = 2, 3, ... while d*d <= n
// ----------------------------------------------------------------------------
module tdpc_ctrl
  import tdpc_pkg::*;
#(
  parameter int NUM_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] number,
  input  logic             res_ready,
  output logic             idle,
  output tdpc_res_t        res
);

  localparam int DIV_W = (NUM_W + 1) / 2 + 1;  // holds 2**ceil(n/2)
  localparam int SQ_W  = 2 * DIV_W;

  tdpc_state_t      state_r;
  logic [NUM_W-1:0] num_r;
  logic [DIV_W-1:0] div_r;
  logic [SQ_W-1:0]  sq_r;      // div_r squared, kept by increments
  logic             prime_r;
  logic             rem_start;
  logic             rem_done;
  logic             rem_zero;

  assign rem_start = (state_r == ST_CHECK) && (sq_r <= SQ_W'(num_r));

  tdpc_rem_unit #(
    .NUM_W(NUM_W),
    .DIV_W(DIV_W)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (num_r),
    .divisor  (div_r),
    .done     (rem_done),
    .rem_zero (rem_zero)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            // 0 and 1 are not prime
            state_r <= (number[NUM_W-1:1] == '0) ? ST_DONE : ST_CHECK;
          end
        end
        ST_CHECK: begin
          state_r <= rem_start ? ST_DIV : ST_DONE;
        end
        ST_DIV: begin
          if (rem_done) begin
            state_r <= rem_zero ? ST_DONE : ST_CHECK;
          end
        end
        ST_DONE: begin
          if (res_ready) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        num_r   <= number;
        div_r   <= DIV_W'(2);
        sq_r    <= SQ_W'(4);
        prime_r <= 1'b0;
      end
      ST_CHECK: begin
        if (!rem_start) begin
          prime_r <= 1'b1;
        end
      end
      ST_DIV: begin
        if (rem_done && !rem_zero) begin
          sq_r  <= sq_r + SQ_W'({div_r, 1'b1});
          div_r <= div_r + DIV_W'(1);
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign idle      = (state_r == ST_IDLE);
  assign res.valid = (state_r == ST_DONE);
  assign res.prime = prime_r;

endmodule

// ===== src/trial_division_prime_counter.sv =====
// ----------------------------------------------------------------------------
// trial_division_prime_counter
// primality test by trial division with a saturating running prime count
// ----------------------------------------------------------------------------
// Each input item carries a candidate (in_tdata) and a range-start flag
// (in_tuser). The candidate is tested by trial division with divisors 2, 3,
// 4, ... until the divisor squared exceeds it; 0 and 1 are reported as not
// prime. One result item follows per input item with the candidate, the prime
// flag and the number of primes since the last range start, this item
// included, saturating at 65535. Items are handled one at a time: in_tready is
// high only while the block is idle. Every divisor costs one bound check plus
// a bit-serial remainder that takes one dividend bit per cycle; a prime n tries
// every divisor from 2 to floor(sqrt(n)), and fewer are tried when a small
// divisor is found. NUM_W is the smaller of NUMBER_BITS and 16, and only that
// many low candidate bits are used. A finished result sits in the output
// register while the next item may already be accepted.
// ----------------------------------------------------------------------------
module trial_division_prime_counter
  import tdpc_pkg::*;
#(
  parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [CAND_W-1:0]      in_tdata,   // [15:0] candidate
  input  logic                   in_tuser,   // [0] range_start
  // result channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [15:0] candidate_echo,
                                             // [16] is_prime,
                                             // [32:17] prime_total, rest zero
);

  // effective candidate width
  localparam int NUM_W = (NUMBER_BITS < CAND_W) ? NUMBER_BITS : CAND_W;

  logic             in_acc;
  logic             ctrl_idle;
  logic             res_ready;
  tdpc_res_t        res;
  logic [NUM_W-1:0] cand_r;       // candidate under test
  logic             start_r;      // range start of the item under test
  logic [CNT_W-1:0] count_r;      // running prime count
  logic [CNT_W-1:0] count_base;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  logic [CAND_W-1:0] echo_r;
  logic             prime_out_r;
  logic [CNT_W-1:0] total_r;

  assign in_tready = ctrl_idle;
  assign in_acc    = in_tvalid && in_tready;

  // the verdict moves to the output register once that is free
  assign res_ready = !out_valid_r || out_tready;

  tdpc_ctrl #(
    .NUM_W(NUM_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_acc),
    .number    (in_tdata[NUM_W-1:0]),
    .res_ready (res_ready),
    .idle      (ctrl_idle),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cand_r  <= in_tdata[NUM_W-1:0];
      start_r <= in_tuser;
    end
  end

  // range start clears the count before this item, saturate at the top
  always_comb begin
    count_base = start_r ? '0 : count_r;
    if (res.prime && count_base != CNT_MAX) begin
      count_nxt = count_base + CNT_W'(1);
    end else begin
      count_nxt = count_base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (res.valid && res_ready) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      echo_r      <= CAND_W'(cand_r);
      prime_out_r <= res.prime;
      total_r     <= count_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - CAND_W - 1 - CNT_W)'(0), total_r, prime_out_r, echo_r};

  // a prime result always carries a non-zero count
  a_prime_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[CAND_W]) |-> (out_tdata[CAND_W+CNT_W:CAND_W+1] != '0))
    else $error("prime result with zero count");

  // 0 and 1 never come out as prime
  a_small_not_prime: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[CAND_W-1:1] == '0) |-> !out_tdata[CAND_W])
    else $error("candidate below two flagged prime");

  // the sequencer is busy in the cycle after an item is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("ready again straight after accepting an item");

endmodule
